@@ rtl/core/iqdm_pkg.sv @@
package iqdm_pkg;

    // field widths
    localparam int KIND_W      = 1;
    localparam int INDEX_W     = 10;
    localparam int COEF_IN_W   = 16;
    localparam int BYTE_W      = 8;
    localparam int AMP_OUT_W   = 16;
    localparam int WIN_W       = 16;

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int TAPS_W      = 11;
    localparam int GAIN_W      = 16;
    localparam int CLAMP_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT = 2'd2;

    localparam logic [TAPS_W-1:0]  TAP_COUNT_RESET = 11'd648;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd256;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET     = 16'd32767;

    // word kinds
    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // datapath widths
    localparam int SAMPLE_W  = 10;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_OFFSET = 10'sd255;
    localparam int ACC_W     = 40;
    localparam int HALF_W    = 20;
    localparam int SUM_W     = 80;
    localparam int ROOT_W    = 40;
    localparam int MUL_AW    = 24;
    localparam int GPROD_W   = HALF_W + GAIN_W;
    localparam int SCALED_W  = ROOT_W + GAIN_W;
    localparam int GAIN_SHIFT = 23;
    localparam int AMP_W     = SCALED_W - GAIN_SHIFT;
    localparam int STEP_W    = 3;

    localparam logic [STEP_W-1:0] SQ_LAST_STEP   = 3'd6;
    localparam logic [STEP_W-1:0] GAIN_LAST_STEP = 3'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_MUL_Q,
        ST_ACC_Q,
        ST_ABS,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT,
        ST_GAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } root_res_t;

endpackage

@@ rtl/core/iqdm_if.sv @@
interface iqdm_iq_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    kind;
    logic [iqdm_pkg::INDEX_W-1:0]            coef_index;
    logic signed [iqdm_pkg::COEF_IN_W-1:0]   coef_value;
    logic [iqdm_pkg::BYTE_W-1:0]             i_byte;
    logic [iqdm_pkg::BYTE_W-1:0]             q_byte;

    modport source (output valid, kind, coef_index, coef_value, i_byte, q_byte,
                    input ready);
    modport sink   (input valid, kind, coef_index, coef_value, i_byte, q_byte,
                    output ready);
endinterface

interface iqdm_mag_if;
    logic                              valid;
    logic                              ready;
    logic [iqdm_pkg::AMP_OUT_W-1:0]    amplitude;
    logic [iqdm_pkg::WIN_W-1:0]        window_index;

    modport source (output valid, amplitude, window_index, input ready);
    modport sink   (input valid, amplitude, window_index, output ready);
endinterface

@@ rtl/core/iqdm_mul.sv @@
module iqdm_mul #(
    parameter int AW = 24,
    parameter int BW = 17
) (
    input  logic                     clk,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  prod
);

    logic signed [AW+BW-1:0] prod_reg;

    // registered signed product, shared by the multiply, square and gain steps of the sequencer
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/iqdm_sqrt.sv @@
module iqdm_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [iqdm_pkg::SUM_W-1:0]    radicand,
    output iqdm_pkg::root_res_t           res
);

    localparam int SW    = iqdm_pkg::SUM_W;
    localparam int RW    = iqdm_pkg::ROOT_W;
    localparam int REM_W = RW + 2;
    localparam int CNT_W = $clog2(RW);

    logic [SW-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [REM_W+1:0] trial_rem;
    logic [REM_W+1:0] trial_sub;

    // one result bit per cycle, restoring digit recurrence
    always_comb
    begin
        trial_rem = {rem_reg, rad_reg[SW-1 -: 2]};
        trial_sub = {2'b00, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg + CNT_W'(1);
            if (trial_rem >= trial_sub)
            begin
                rem_next  = REM_W'(trial_rem - trial_sub);
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(trial_rem);
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(RW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule

@@ rtl/core/iq_block_decimator_magnitude.sv @@
// channel  | modport | direction | contents
// iq       | sink    | in        | kind, coef_index, coef_value, i_byte, q_byte
// mag      | source  | out       | amplitude, window_index
// cfg_*    | plain   | in        | write enable, register index, write data
//
// a coefficient word is taken while the sequencer is idle; a sample word passes through
// accept, i multiply, q multiply and q accumulate on the one shared multiplier
// a sample that closes a window adds abs, six square partial products, the bit-serial
// square root, two gain partial products and the emit
// rst_n is asynchronous and clears the sequencer, accumulators, tap position and window
// counter, loads the configuration registers with their reset values; the coefficient memory is not cleared
// the result sits in an output register; the block waits in the emit step only
// while the previous result word has not been taken
module iq_block_decimator_magnitude #(
    parameter int MAX_TAPS  = 1024,
    parameter int COEF_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [iqdm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iqdm_pkg::CFG_DATA_W-1:0]      cfg_data,
    iqdm_iq_if.sink                              iq,
    iqdm_mag_if.source                           mag
);

    // address and tap-count widths follow the store depth
    localparam int PW   = $clog2(MAX_TAPS);
    localparam int TW   = ($clog2(MAX_TAPS + 1) > iqdm_pkg::TAPS_W) ?
                          $clog2(MAX_TAPS + 1) : iqdm_pkg::TAPS_W;
    localparam int CIW  = (PW > iqdm_pkg::INDEX_W) ? PW + 1 : iqdm_pkg::INDEX_W + 1;
    // multiplier b side holds a coefficient, the unsigned gain or an unsigned
    // square half, the widest of which sets its width
    localparam int MB   = (COEF_BITS > iqdm_pkg::HALF_W) ? COEF_BITS
                                                         : iqdm_pkg::HALF_W + 1;
    localparam int AW   = iqdm_pkg::MUL_AW;
    localparam int PRW  = AW + MB;
    localparam int ACCW = iqdm_pkg::ACC_W;
    localparam int HW   = iqdm_pkg::HALF_W;
    localparam int SW   = iqdm_pkg::SUM_W;
    localparam int RW   = iqdm_pkg::ROOT_W;
    localparam int GW   = iqdm_pkg::GPROD_W;
    localparam int SCW  = iqdm_pkg::SCALED_W;
    localparam int AMW  = iqdm_pkg::AMP_W;
    localparam int STW  = iqdm_pkg::STEP_W;

    // configuration registers
    logic [iqdm_pkg::TAPS_W-1:0]  tap_count_reg;
    logic [iqdm_pkg::GAIN_W-1:0]  gain_reg;
    logic [iqdm_pkg::CLAMP_W-1:0] clamp_reg;

    // sequencer and window state
    iqdm_pkg::state_t             state_reg, state_next;
    logic [STW-1:0]               step_reg, step_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic [iqdm_pkg::WIN_W-1:0]   win_reg, win_next;
    logic signed [ACCW-1:0]       acc_i_reg, acc_i_next;
    logic signed [ACCW-1:0]       acc_q_reg, acc_q_next;

    // datapath registers
    logic [iqdm_pkg::BYTE_W-1:0]  i_reg, i_next;
    logic [iqdm_pkg::BYTE_W-1:0]  q_reg, q_next;
    logic [ACCW-1:0]              abs_i_reg, abs_i_next;
    logic [ACCW-1:0]              abs_q_reg, abs_q_next;
    logic [SW-1:0]                sum_reg, sum_next;
    logic [SCW-1:0]               scaled_reg, scaled_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [iqdm_pkg::AMP_OUT_W-1:0] amp_reg, amp_next;
    logic [iqdm_pkg::WIN_W-1:0]   idx_reg, idx_next;

    // coefficient memory
    logic signed [COEF_BITS-1:0]  coef_mem [MAX_TAPS];
    logic signed [COEF_BITS-1:0]  coef_rd_reg;
    logic signed [COEF_BITS-1:0]  coef_wdata;
    logic [PW-1:0]                coef_waddr;
    logic                         coef_we;

    // shared multiplier and square root
    logic signed [AW-1:0]         mul_a;
    logic signed [MB-1:0]         mul_b;
    logic signed [PRW-1:0]        mul_p;
    logic                         sqrt_start;
    iqdm_pkg::root_res_t          root_res;

    // combinational helpers
    logic                         in_take;
    logic                         out_free;
    logic signed [iqdm_pkg::SAMPLE_W-1:0] ci;
    logic signed [iqdm_pkg::SAMPLE_W-1:0] cq;
    logic [ACCW-1:0]              sq_src;
    logic [HW-1:0]                sq_hi;
    logic [HW-1:0]                sq_lo;
    logic [SW-1:0]                sq_term;
    logic [TW-1:0]                taps_eff;
    logic [TW-1:0]                pos_inc;
    logic [AMW-1:0]               amp_wide;
    logic [iqdm_pkg::AMP_OUT_W-1:0] amp_sat;

    assign in_take  = iq.valid && iq.ready;
    assign out_free = !out_valid_reg || mag.ready;

    // ---------------------------------------------------------------
    // configuration writes, unknown index ignored
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= iqdm_pkg::TAP_COUNT_RESET;
            gain_reg      <= iqdm_pkg::GAIN_RESET;
            clamp_reg     <= iqdm_pkg::CLAMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                iqdm_pkg::REG_TAP_COUNT:
                    tap_count_reg <= cfg_data[iqdm_pkg::TAPS_W-1:0];
                iqdm_pkg::REG_GAIN:
                    gain_reg <= cfg_data[iqdm_pkg::GAIN_W-1:0];
                iqdm_pkg::REG_CLAMP_LIMIT:
                    clamp_reg <= cfg_data[iqdm_pkg::CLAMP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // coefficient store: one write port, read at the tap position
    // ---------------------------------------------------------------
    assign coef_we    = in_take && (iq.kind == iqdm_pkg::KIND_COEF) &&
                        (CIW'(iq.coef_index) < CIW'(MAX_TAPS));
    assign coef_waddr = PW'(iq.coef_index);
    // truncates or sign-extends the 16-bit word to the stored width
    assign coef_wdata = COEF_BITS'(iq.coef_value);

    // the read at the accepting edge sees every earlier write
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rd_reg <= coef_mem[pos_reg];
    end

    // ---------------------------------------------------------------
    // shared units
    // ---------------------------------------------------------------
    iqdm_mul #(
        .AW (AW),
        .BW (MB)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    iqdm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .res      (root_res)
    );

    // centred samples: 2*b - 255
    assign ci = $signed({1'b0, i_reg, 1'b0}) - iqdm_pkg::SAMPLE_OFFSET;
    assign cq = $signed({1'b0, q_reg, 1'b0}) - iqdm_pkg::SAMPLE_OFFSET;

    // squares are built from 20-bit halves: hh<<40 + 2*hl<<20 + ll
    assign sq_src = (step_reg < STW'(3)) ? abs_i_reg : abs_q_reg;
    assign sq_hi  = sq_src[ACCW-1:HW];
    assign sq_lo  = sq_src[HW-1:0];

    // zero tap count acts as one, anything above the store depth saturates
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_eff = TW'(1);
        end
        else if (TW'(tap_count_reg) > TW'(MAX_TAPS))
        begin
            taps_eff = TW'(MAX_TAPS);
        end
        else
        begin
            taps_eff = TW'(tap_count_reg);
        end
    end

    assign pos_inc  = TW'(pos_reg) + TW'(1);
    assign amp_wide = scaled_reg[SCW-1:iqdm_pkg::GAIN_SHIFT];
    assign amp_sat  = (amp_wide > AMW'(clamp_reg)) ? clamp_reg
                                                   : amp_wide[iqdm_pkg::AMP_OUT_W-1:0];

    // multiplier operand selection per sequencer step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            iqdm_pkg::ST_MUL_I:
            begin
                mul_a = AW'(ci);
                mul_b = MB'(coef_rd_reg);
            end
            iqdm_pkg::ST_MUL_Q:
            begin
                mul_a = AW'(cq);
                mul_b = MB'(coef_rd_reg);
            end
            iqdm_pkg::ST_SQUARE:
            begin
                case (step_reg)
                    3'd0, 3'd3:
                    begin
                        mul_a = AW'(sq_hi);
                        mul_b = MB'(sq_hi);
                    end
                    3'd1, 3'd4:
                    begin
                        mul_a = AW'(sq_hi);
                        mul_b = MB'(sq_lo);
                    end
                    3'd2, 3'd5:
                    begin
                        mul_a = AW'(sq_lo);
                        mul_b = MB'(sq_lo);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            iqdm_pkg::ST_GAIN:
            begin
                mul_a = (step_reg == '0) ? AW'(root_res.root[RW-1:HW])
                                         : AW'(root_res.root[HW-1:0]);
                mul_b = MB'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product issued one step earlier, placed at its weight
    always_comb
    begin
        case (step_reg)
            3'd1, 3'd4: sq_term = SW'(mul_p[2*HW-1:0]) << (2 * HW);
            3'd2, 3'd5: sq_term = SW'(mul_p[2*HW-1:0]) << (HW + 1);
            3'd3, 3'd6: sq_term = SW'(mul_p[2*HW-1:0]);
            default:    sq_term = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        win_next       = win_reg;
        acc_i_next     = acc_i_reg;
        acc_q_next     = acc_q_reg;
        i_next         = i_reg;
        q_next         = q_reg;
        abs_i_next     = abs_i_reg;
        abs_q_next     = abs_q_reg;
        sum_next       = sum_reg;
        scaled_next    = scaled_reg;
        amp_next       = amp_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !mag.ready;
        sqrt_start     = 1'b0;
        iq.ready       = 1'b0;

        case (state_reg)
            iqdm_pkg::ST_IDLE:
            begin
                iq.ready = 1'b1;
                if (iq.valid && (iq.kind == iqdm_pkg::KIND_SAMPLE))
                begin
                    i_next     = iq.i_byte;
                    q_next     = iq.q_byte;
                    state_next = iqdm_pkg::ST_MUL_I;
                end
            end
            iqdm_pkg::ST_MUL_I:
            begin
                state_next = iqdm_pkg::ST_MUL_Q;
            end
            iqdm_pkg::ST_MUL_Q:
            begin
                acc_i_next = acc_i_reg + ACCW'(mul_p);
                state_next = iqdm_pkg::ST_ACC_Q;
            end
            iqdm_pkg::ST_ACC_Q:
            begin
                acc_q_next = acc_q_reg + ACCW'(mul_p);
                if (pos_inc < taps_eff)
                begin
                    pos_next   = PW'(pos_inc);
                    state_next = iqdm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = iqdm_pkg::ST_ABS;
                end
            end
            iqdm_pkg::ST_ABS:
            begin
                abs_i_next = acc_i_reg[ACCW-1] ? ACCW'(-acc_i_reg) : ACCW'(acc_i_reg);
                abs_q_next = acc_q_reg[ACCW-1] ? ACCW'(-acc_q_reg) : ACCW'(acc_q_reg);
                sum_next   = '0;
                step_next  = '0;
                state_next = iqdm_pkg::ST_SQUARE;
            end
            iqdm_pkg::ST_SQUARE:
            begin
                sum_next = sum_reg + sq_term;
                if (step_reg == iqdm_pkg::SQ_LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = iqdm_pkg::ST_ROOT_GO;
                end
                else
                begin
                    step_next = step_reg + STW'(1);
                end
            end
            iqdm_pkg::ST_ROOT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = iqdm_pkg::ST_ROOT;
            end
            iqdm_pkg::ST_ROOT:
            begin
                if (root_res.done)
                begin
                    step_next  = '0;
                    state_next = iqdm_pkg::ST_GAIN;
                end
            end
            iqdm_pkg::ST_GAIN:
            begin
                if (step_reg == STW'(1))
                begin
                    scaled_next = SCW'(mul_p[GW-1:0]) << HW;
                end
                else if (step_reg == iqdm_pkg::GAIN_LAST_STEP)
                begin
                    scaled_next = scaled_reg + SCW'(mul_p[GW-1:0]);
                end
                if (step_reg == iqdm_pkg::GAIN_LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = iqdm_pkg::ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + STW'(1);
                end
            end
            iqdm_pkg::ST_EMIT:
            begin
                // hold until the previous result word leaves
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    amp_next       = amp_sat;
                    idx_next       = win_reg;
                    win_next       = win_reg + iqdm_pkg::WIN_W'(1);
                    acc_i_next     = '0;
                    acc_q_next     = '0;
                    pos_next       = '0;
                    state_next     = iqdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iqdm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iqdm_pkg::ST_IDLE;
            step_reg      <= '0;
            pos_reg       <= '0;
            win_reg       <= '0;
            acc_i_reg     <= '0;
            acc_q_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            win_reg       <= win_next;
            acc_i_reg     <= acc_i_next;
            acc_q_reg     <= acc_q_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        q_reg      <= q_next;
        abs_i_reg  <= abs_i_next;
        abs_q_reg  <= abs_q_next;
        sum_reg    <= sum_next;
        scaled_reg <= scaled_next;
        amp_reg    <= amp_next;
        idx_reg    <= idx_next;
    end

    assign mag.valid        = out_valid_reg;
    assign mag.amplitude    = amp_reg;
    assign mag.window_index = idx_reg;

endmodule

@@ rtl/core/iqdm_checker.sv @@
module iqdm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              in_kind,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [iqdm_pkg::AMP_OUT_W-1:0]    amplitude,
    input logic [iqdm_pkg::WIN_W-1:0]        window_index,
    input logic                              cfg_we,
    input logic [iqdm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [iqdm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [iqdm_pkg::CLAMP_W-1:0] clamp_seen_reg;
    logic [iqdm_pkg::WIN_W-1:0]   last_idx_reg;
    logic                         seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_seen_reg <= iqdm_pkg::CLAMP_RESET;
            last_idx_reg   <= '0;
            seen_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == iqdm_pkg::REG_CLAMP_LIMIT))
            begin
                clamp_seen_reg <= cfg_data[iqdm_pkg::CLAMP_W-1:0];
            end
            if (out_valid && out_ready)
            begin
                last_idx_reg <= window_index;
                seen_reg     <= 1'b1;
            end
        end
    end

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(amplitude)
                                    && $stable(window_index))
    else $error("result word changed while stalled");

    // a sample keeps the sequencer busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_kind == iqdm_pkg::KIND_SAMPLE) |=> !in_ready)
    else $error("sample word accepted back to back");

    // amplitude never above the programmed limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> amplitude <= clamp_seen_reg)
    else $error("amplitude above clamp limit");

    // windows are numbered consecutively
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && seen_reg |-> window_index == last_idx_reg + 16'd1)
    else $error("window index skipped or repeated");

endmodule

bind iq_block_decimator_magnitude iqdm_checker u_iqdm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (iq.valid),
    .in_ready     (iq.ready),
    .in_kind      (iq.kind),
    .out_valid    (mag.valid),
    .out_ready    (mag.ready),
    .amplitude    (mag.amplitude),
    .window_index (mag.window_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TAPS     = 1024;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    // settling room after a sample closing a window, plus a stalled result word
    localparam int SETTLE       = 90;
    localparam int WORDS_TARGET = 1350;
    localparam int CYCLE_LIMIT  = 1000000;

    // index 3 is a hole in the register map, writes there change nothing
    localparam logic [iqdm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [iqdm_pkg::COEF_IN_W-1:0] COEF_MAX = 16'sh7fff;
    localparam logic signed [iqdm_pkg::COEF_IN_W-1:0] COEF_MIN = -16'sh8000;

    typedef struct packed {
        logic                                  kind;
        logic [iqdm_pkg::INDEX_W-1:0]          coef_index;
        logic signed [iqdm_pkg::COEF_IN_W-1:0] coef_value;
        logic [iqdm_pkg::BYTE_W-1:0]           i_byte;
        logic [iqdm_pkg::BYTE_W-1:0]           q_byte;
    } iq_word_t;

    typedef struct packed {
        logic [iqdm_pkg::AMP_OUT_W-1:0] amplitude;
        logic [iqdm_pkg::WIN_W-1:0]     window_index;
    } mag_word_t;

    // clock, reset and configuration port
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [iqdm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [iqdm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // bench-side copies of the channel signals, known from time zero
    logic     src_valid  = 1'b0;
    iq_word_t drive_word = '0;
    logic     sink_ready = 1'b0;

    iqdm_iq_if  iq ();
    iqdm_mag_if mag ();

    assign iq.valid      = src_valid;
    assign iq.kind       = drive_word.kind;
    assign iq.coef_index = drive_word.coef_index;
    assign iq.coef_value = drive_word.coef_value;
    assign iq.i_byte     = drive_word.i_byte;
    assign iq.q_byte     = drive_word.q_byte;
    assign mag.ready     = sink_ready;

    iq_block_decimator_magnitude u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .iq        (iq),
        .mag       (mag)
    );

    always #(CLK_HALF) clk = ~clk;

    // words waiting to be offered, and window results still owed by the block
    iq_word_t  pending[$];
    mag_word_t windows_due[$];
    mag_word_t due_word;

    // shadow of the registers, shared by the stimulus and the filter model
    logic [iqdm_pkg::TAPS_W-1:0]  cfg_taps  = iqdm_pkg::TAP_COUNT_RESET;
    logic [iqdm_pkg::GAIN_W-1:0]  cfg_gain  = iqdm_pkg::GAIN_RESET;
    logic [iqdm_pkg::CLAMP_W-1:0] cfg_clamp = iqdm_pkg::CLAMP_RESET;

    // filter model state, advanced only by accepted words
    logic signed [iqdm_pkg::COEF_IN_W-1:0] coef_mem [MAX_TAPS];
    logic [iqdm_pkg::ACC_W-1:0]            acc_i     = '0;
    logic [iqdm_pkg::ACC_W-1:0]            acc_q     = '0;
    logic [iqdm_pkg::INDEX_W-1:0]          tap_pos   = '0;
    logic [iqdm_pkg::WIN_W-1:0]            win_count = '0;

    // stimulus side: which taps hold a coefficient, and where the window will be
    bit coef_loaded [MAX_TAPS];
    int gen_pos      = 0;
    int words_queued = 0;

    // idling control and counters
    bit idle_on        = 1'b1;
    int src_gap        = 0;
    int sink_gap       = 0;
    int mismatches     = 0;
    int coef_words     = 0;
    int sample_words   = 0;
    int windows_seen   = 0;
    int reg_writes     = 0;
    int phases         = 0;
    int phase_len;

    // tap count as the block uses it: zero acts as one, saturates at the store depth
    function automatic int eff_taps(input logic [iqdm_pkg::TAPS_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > MAX_TAPS)
            return MAX_TAPS;
        return int'(n);
    endfunction

    // floor(sqrt(i^2 + q^2)) of two 40-bit two's complement accumulators
    function automatic logic [iqdm_pkg::ACC_W:0] iq_magnitude(
            input logic [iqdm_pkg::ACC_W-1:0] ai,
            input logic [iqdm_pkg::ACC_W-1:0] aq);
        logic [81:0]                  ui;
        logic [81:0]                  uq;
        logic [81:0]                  power;
        logic [81:0]                  trial;
        logic [iqdm_pkg::ACC_W:0]     root;
        ui    = ai[iqdm_pkg::ACC_W-1] ? {42'd0, (~ai) + 40'd1} : {42'd0, ai};
        uq    = aq[iqdm_pkg::ACC_W-1] ? {42'd0, (~aq) + 40'd1} : {42'd0, aq};
        power = ui * ui + uq * uq;
        root  = '0;
        for (int k = iqdm_pkg::ACC_W; k >= 0; k--)
        begin
            trial = {41'd0, root} | (82'd1 << k);
            if (trial * trial <= power)
                root = trial[iqdm_pkg::ACC_W:0];
        end
        return root;
    endfunction

    // one accepted word through the filter model; a window end owes a result
    function automatic void decimate_word(input iq_word_t w);
        int                       taps;
        int                       coef;
        int                       ci;
        int                       cq;
        longint                   prod_i;
        longint                   prod_q;
        logic [iqdm_pkg::ACC_W:0] root;
        logic [63:0]              scaled;
        mag_word_t                res;
        if (w.kind == iqdm_pkg::KIND_COEF)
        begin
            coef_mem[w.coef_index] = w.coef_value;
            return;
        end
        taps   = eff_taps(cfg_taps);
        coef   = coef_mem[tap_pos];
        ci     = 2 * int'(w.i_byte) - 255;
        cq     = 2 * int'(w.q_byte) - 255;
        prod_i = longint'(ci) * longint'(coef);
        prod_q = longint'(cq) * longint'(coef);
        acc_i  = acc_i + prod_i[iqdm_pkg::ACC_W-1:0];
        acc_q  = acc_q + prod_q[iqdm_pkg::ACC_W-1:0];
        if (int'(tap_pos) + 1 < taps)
        begin
            tap_pos = tap_pos + 1'b1;
            return;
        end
        root   = iq_magnitude(acc_i, acc_q);
        scaled = (64'(root) * 64'(cfg_gain)) >> iqdm_pkg::GAIN_SHIFT;
        if (scaled > 64'(cfg_clamp))
            scaled = 64'(cfg_clamp);
        res.amplitude    = scaled[iqdm_pkg::AMP_OUT_W-1:0];
        res.window_index = win_count;
        windows_due.insert(windows_due.size(), res);
        win_count = win_count + 1'b1;
        acc_i     = '0;
        acc_q     = '0;
        tap_pos   = '0;
    endfunction

    function automatic logic [iqdm_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic signed [iqdm_pkg::COEF_IN_W-1:0] pick_coef();
        case ($urandom_range(0, 19))
            0, 1: return COEF_MAX;
            2, 3: return COEF_MIN;
            4: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short windows so results come often, now and then huge or odd counts
    function automatic logic [iqdm_pkg::CFG_DATA_W-1:0] pick_taps();
        case ($urandom_range(0, 19))
            0: return 16'd0;
            1: return 16'd1024;
            2: return 16'd2047;
            3: return 16'($urandom_range(1025, 2046));
            4, 5, 6: return 16'($urandom_range(13, 64));
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [iqdm_pkg::CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'd256;
            3: return 16'($urandom_range(0, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_coef(input int idx,
                                       input logic signed [iqdm_pkg::COEF_IN_W-1:0] val);
        iq_word_t w;
        w.kind       = iqdm_pkg::KIND_COEF;
        w.coef_index = idx[iqdm_pkg::INDEX_W-1:0];
        w.coef_value = val;
        w.i_byte     = 8'($urandom);
        w.q_byte     = 8'($urandom);
        coef_loaded[idx] = 1'b1;
        pending.insert(pending.size(), w);
        words_queued++;
    endfunction

    // a sample never reaches a tap that has not been loaded: load it first
    function automatic void queue_sample(input logic [iqdm_pkg::BYTE_W-1:0] ib,
                                         input logic [iqdm_pkg::BYTE_W-1:0] qb);
        iq_word_t w;
        if (!coef_loaded[gen_pos])
            queue_coef(gen_pos, pick_coef());
        w.kind       = iqdm_pkg::KIND_SAMPLE;
        w.coef_index = 10'($urandom);
        w.coef_value = 16'($urandom);
        w.i_byte     = ib;
        w.q_byte     = qb;
        pending.insert(pending.size(), w);
        words_queued++;
        gen_pos = (gen_pos + 1 < eff_taps(cfg_taps)) ? gen_pos + 1 : 0;
    endfunction

    task automatic write_reg(input logic [iqdm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iqdm_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            iqdm_pkg::REG_TAP_COUNT:   cfg_taps  = val[iqdm_pkg::TAPS_W-1:0];
            iqdm_pkg::REG_GAIN:        cfg_gain  = val[iqdm_pkg::GAIN_W-1:0];
            iqdm_pkg::REG_CLAMP_LIMIT: cfg_clamp = val[iqdm_pkg::CLAMP_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // block idle: every word offered and taken, every owed window delivered,
    // then room for a sample still in the multiplier or root pipeline
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending.size() != 0 || src_valid || windows_due.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // driver: offers queued words, with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_gap    = 0;
        end
        else
        begin
            // word taken at this edge: advance the filter model
            if (src_valid && iq.ready)
            begin
                decimate_word(drive_word);
                if (drive_word.kind == iqdm_pkg::KIND_COEF)
                    coef_words++;
                else
                    sample_words++;
            end
            // the slot is free if nothing was shown or it has just gone
            if (!src_valid || iq.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    src_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    drive_word <= pending.pop_front();
                    src_valid  <= 1'b1;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 17);
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: takes result words with random stalls and checks each one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            sink_gap    = 0;
        end
        else
        begin
            if (mag.valid && sink_ready)
            begin
                windows_seen++;
                if (windows_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with none owed: amplitude %0d window %0d",
                                 mag.amplitude, mag.window_index);
                end
                else
                begin
                    due_word = windows_due.pop_front();
                    if (mag.amplitude !== due_word.amplitude ||
                        mag.window_index !== due_word.window_index)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"window result: expected amplitude %0d window %0d,",
                                      " got amplitude %0d window %0d"},
                                     due_word.amplitude, due_word.window_index,
                                     mag.amplitude, mag.window_index);
                    end
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                sink_ready <= 1'b0;
            end
            else
            begin
                sink_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 17);
            end
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("iq_block_decimator_magnitude verification failed");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings still in force: taps 648, gain 256, default clamp
        queue_coef(0, COEF_MAX);
        queue_coef(1, COEF_MIN);
        queue_coef(2, '0);
        queue_coef(3, 16'sd1);
        queue_coef(MAX_TAPS - 1, 16'sh5a5a);
        // three samples into a long window, nothing may come out
        queue_sample(8'hff, 8'hff);
        queue_sample(8'h00, 8'h00);
        queue_sample(8'h00, 8'hff);
        wait_quiet();

        write_reg(REG_UNUSED, 16'hffff);
        // count lowered below the position already reached: next sample closes it
        write_reg(iqdm_pkg::REG_TAP_COUNT, 16'd2);
        queue_sample(8'hff, 8'h00);
        queue_sample(8'hff, 8'hff);
        queue_sample(8'h00, 8'h00);
        wait_quiet();

        // zero taps behaves as one tap per window
        write_reg(iqdm_pkg::REG_TAP_COUNT, 16'd0);
        queue_sample(8'hff, 8'hff);
        queue_sample(8'h00, 8'h00);
        wait_quiet();

        // largest gain and clamp, so the saturation bound is reached
        write_reg(iqdm_pkg::REG_TAP_COUNT, 16'd1);
        write_reg(iqdm_pkg::REG_GAIN, 16'hffff);
        write_reg(iqdm_pkg::REG_CLAMP_LIMIT, 16'hffff);
        queue_sample(8'hff, 8'hff);
        queue_sample(8'h00, 8'hff);
        wait_quiet();

        write_reg(iqdm_pkg::REG_CLAMP_LIMIT, 16'h0000);
        queue_sample(8'hff, 8'h00);
        wait_quiet();

        write_reg(iqdm_pkg::REG_GAIN, 16'h0000);
        write_reg(iqdm_pkg::REG_CLAMP_LIMIT, 16'hffff);
        queue_sample(8'h00, 8'h00);
        wait_quiet();

        // random phases, each of which may rewrite some settings; no idling over the last stretch
        while (words_queued < WORDS_TARGET)
        begin
            idle_on = (words_queued < WORDS_TARGET * 85 / 100) &&
                      ($urandom_range(0, 4) != 0);
            if (phases == 0 || $urandom_range(0, 2) == 0)
                write_reg(iqdm_pkg::REG_TAP_COUNT, pick_taps());
            if (phases == 0 || $urandom_range(0, 2) == 0)
                write_reg(iqdm_pkg::REG_GAIN, pick_level());
            if (phases == 0 || $urandom_range(0, 2) == 0)
                write_reg(iqdm_pkg::REG_CLAMP_LIMIT, pick_level());
            phase_len = $urandom_range(30, 90);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 9) < 7)
                    queue_sample(pick_byte(), pick_byte());
                else if ($urandom_range(0, 1) == 0)
                    queue_coef($urandom_range(0, eff_taps(cfg_taps) - 1), pick_coef());
                else
                    queue_coef($urandom_range(0, MAX_TAPS - 1), pick_coef());
            end
            wait_quiet();
            phases++;
        end

        $display("run covered %0d coefficient loads and %0d samples in %0d random phases",
                 coef_words, sample_words, phases);
        $display("%0d window results checked, %0d register writes, %0d mismatches",
                 windows_seen, reg_writes, mismatches);
        if (mismatches == 0)
            $display("iq_block_decimator_magnitude verification clean");
        else
            $display("iq_block_decimator_magnitude verification failed");
        $finish;
    end

endmodule
